[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define LPI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define LPI_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LPI_ASSERT(lbl, clk, rst, prop, msg)
`define LPI_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

[rtl/lpi_pkg.sv]
// types and constants of the literal pool interner
`timescale 1ns / 1ps
package lpi_pkg;
   localparam int unsigned POOL_DEPTH_DEF = 256;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned INDEX_W = 8;

   localparam logic [ACTION_W-1:0] ACT_INT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FLT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FUNC = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   localparam logic [VALUE_W-1:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] EXP_ALL = 64'h7FF0_0000_0000_0000;

   typedef struct packed {
      logic [ACTION_W-1:0] kind;
      logic [VALUE_W-1:0] value;
   } entry_type;
endpackage

[rtl/lpi_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
interface lpi_req_if import lpi_pkg::*; ();
   logic valid;
   logic ready;
   logic [ACTION_W-1:0] action;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink (input valid, action, value, output ready);
endinterface

interface lpi_rsp_if import lpi_pkg::*; ();
   logic valid;
   logic ready;
   logic [INDEX_W-1:0] index;
   logic found;
   logic full_res;

   modport source (output valid, index, found, full_res, input ready);
   modport sink (input valid, index, found, full_res, output ready);
endinterface

[rtl/lpi_store.sv]
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module lpi_store import lpi_pkg::*; #(
   parameter int unsigned DEPTH = POOL_DEPTH_DEF,
   parameter int unsigned ADDR_W = $clog2(POOL_DEPTH_DEF)
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type rd_data
);
   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/lpi_cmp.sv]
// compare unit: tag match plus integer or ieee double equality
`timescale 1ns / 1ps
module lpi_cmp import lpi_pkg::*; (
   input  logic [ACTION_W-1:0] action,
   input  logic [VALUE_W-1:0] value,
   input  entry_type entry,
   output logic hit
);
   logic req_nan;
   logic ent_nan;
   logic both_zero;
   logic bits_eq;
   logic flt_eq;

   always_comb begin
      req_nan = (value & ABS_MASK) > EXP_ALL;
      ent_nan = (entry.value & ABS_MASK) > EXP_ALL;
      both_zero = ((value & ABS_MASK) == '0) && ((entry.value & ABS_MASK) == '0);
      bits_eq = value == entry.value;
      flt_eq = !req_nan && !ent_nan && (both_zero || bits_eq);
      hit = 1'b0;
      if (entry.kind == action) begin
         case (action)
            ACT_INT: hit = bits_eq;
            ACT_FLT: hit = flt_eq;
            default: hit = 1'b0;
         endcase
      end
   end
endmodule

[rtl/literal_pool_interner_unit.sv]
// top level of the literal pool interner
`timescale 1ns / 1ps
// Interns integer and double constants in a table of POOL_DEPTH entries, emptied at reset.
// An integer or float request reads the stored entries one per cycle through the single
// read port of the entry memory, from index 0 upward, and stops at the first equal entry
// of the same kind; a miss appends the value unless the table is full, which sets full_res.
// A function handle skips the scan and is appended with no search, unless the table is full;
// an unused action skips the scan and is not stored. One request is in work at a time;
// a finished response sits in an output register and the next request is taken while it
// waits, but the following response holds until the output register has been taken.
`include "assert_macros.svh"
module literal_pool_interner_unit import lpi_pkg::*; #(
   parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   lpi_req_if.sink req_ch,
   lpi_rsp_if.source rsp_ch
);
   localparam int unsigned ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type state_ff, state_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic pend_ff, pend_in;
   logic [ADDR_W-1:0] pidx_ff, pidx_in;
   logic found_ff, found_in;
   logic [ADDR_W-1:0] fidx_ff, fidx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic rsp_found_ff, rsp_found_in;
   logic rsp_full_ff, rsp_full_in;

   logic slot_free;
   logic issue;
   logic hit;
   logic at_full;
   logic act_ok;
   logic wr_en;
   entry_type wr_data;
   entry_type rd_data;

   lpi_store #(.DEPTH(POOL_DEPTH), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   lpi_cmp u_cmp (
      .action (act_ff),
      .value  (val_ff),
      .entry  (rd_data),
      .hit    (hit)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign issue = (state_ff == ST_SCAN) && (ptr_ff != count_ff);
   assign at_full = count_ff == CNT_W'(POOL_DEPTH);
   assign act_ok = act_ff != ACT_NONE;
   assign wr_en = (state_ff == ST_FINISH) && slot_free && !found_ff && act_ok && !at_full;
   assign wr_data = '{kind: act_ff, value: val_ff};

   assign req_ch.ready = state_ff == ST_IDLE;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.index = rsp_index_ff;
   assign rsp_ch.found = rsp_found_ff;
   assign rsp_ch.full_res = rsp_full_ff;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      val_in = val_ff;
      ptr_in = ptr_ff;
      pend_in = pend_ff;
      pidx_in = pidx_ff;
      found_in = found_ff;
      fidx_in = fidx_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in = rsp_index_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in = rsp_full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               act_in = req_ch.action;
               val_in = req_ch.value;
               ptr_in = '0;
               pend_in = 1'b0;
               found_in = 1'b0;
               if (req_ch.action == ACT_INT || req_ch.action == ACT_FLT) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            pend_in = issue;
            pidx_in = ptr_ff[ADDR_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (pend_ff && hit) begin
               found_in = 1'b1;
               fidx_in = pidx_ff;
               pend_in = 1'b0;
               state_in = ST_FINISH;
            end else if (!pend_ff && !issue) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_full_in = !found_ff && act_ok && at_full;
               if (found_ff) begin
                  rsp_index_in = INDEX_W'(fidx_ff);
               end else if (wr_en) begin
                  rsp_index_in = INDEX_W'(count_ff);
               end else begin
                  rsp_index_in = '0;
               end
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         found_ff <= found_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;
      val_ff <= val_in;
      ptr_ff <= ptr_in;
      pidx_ff <= pidx_in;
      fidx_ff <= fidx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff <= rsp_full_in;
   end

   `LPI_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(POOL_DEPTH), "fill count past depth")
   `LPI_NEVER(a_found_full, clock, reset, rsp_valid_ff && rsp_found_ff && rsp_full_ff, "found with full")
   `LPI_ASSERT(a_grow, clock, reset, (!$past(reset) && count_ff != $past(count_ff)) |-> $past(wr_en), "count moved without append")
   `LPI_ASSERT(a_scan_ptr, clock, reset, (state_ff == ST_SCAN) |-> (ptr_ff <= count_ff), "scan pointer past fill count")
endmodule
